// ===== hw/rtl/mfts_pkg.sv =====
package mfts_pkg;

	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);

	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_TICK    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	localparam logic [1:0] CFG_QUANTUM_FIRST  = 2'd0;
	localparam logic [1:0] CFG_QUANTUM_SECOND = 2'd1;
	localparam logic [1:0] CFG_QUANTUM_THIRD  = 2'd2;
	localparam logic [1:0] CFG_MAX_BURST      = 2'd3;

	localparam logic [2:0] LVL_NONE   = 3'd0;
	localparam logic [2:0] LVL_FIRST  = 3'd1;
	localparam logic [2:0] LVL_SECOND = 3'd2;
	localparam logic [2:0] LVL_THIRD  = 3'd3;
	localparam logic [2:0] LVL_LAST   = 3'd4;

	localparam int NUM_LEVELS = 4;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] burst_time;
	} req_item_t;

	typedef struct packed {
		logic       load_accepted;
		logic       load_rejected;
		logic       ran;
		logic [3:0] process_id;
		logic [2:0] run_level;
		logic [7:0] time_left;
		logic       demoted;
		logic       finished;
		logic       all_done;
	} res_item_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} dp_cmd_t;

endpackage

// ===== hw/rtl/mfts_ctrl.sv =====
module mfts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	output logic           res_valid,
	input  logic           res_stall,
	output mfts_pkg::dp_cmd_t cmd
);
	import mfts_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   accept;

	// take a new request only when the result slot is empty or drains now
	assign req_stall = !((state_q == ST_IDLE) && (!res_valid_q || !res_stall));
	assign accept    = req_valid && !req_stall;
	assign res_valid = res_valid_q;

	assign cmd.capture = accept;
	assign cmd.exec    = (state_q == ST_EXEC);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/mfts_dp.sv =====
module mfts_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mfts_pkg::dp_cmd_t   cmd,
	input  mfts_pkg::req_item_t req,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	output mfts_pkg::res_item_t res
);
	import mfts_pkg::*;

	// configuration
	logic [5:0] quant1_q, quant2_q, quant3_q;
	logic [7:0] max_burst_q;

	// process table
	logic [2:0] level_q [MAX_PROCS];
	logic [2:0] level_d [MAX_PROCS];
	logic [7:0] rem_q   [MAX_PROCS];

	// scheduling state
	logic [CNT_W-1:0] count_q, count_d;
	logic [2:0]       serv_q, serv_d;
	logic [CNT_W-1:0] scan_q, scan_d;
	logic [5:0]       slice_q, slice_d;
	logic             running_q, running_d;

	req_item_t item_q;
	res_item_t res_q, res_d;

	// search
	logic [MAX_PROCS-1:0] lvl_mask [NUM_LEVELS];
	logic [MAX_PROCS-1:0] sel_mask;
	logic                 found;
	logic [2:0]           plvl;
	logic [IDX_W-1:0]     pick;
	logic [7:0]           rem_cur, after;
	logic [5:0]           slice_base, slice_inc, qsel, qeff;
	logic                 rem_we;
	logic [IDX_W-1:0]     rem_idx;
	logic [7:0]           rem_wdata;
	logic                 any_left;

	always_comb begin
		for (int l = 0; l < NUM_LEVELS; l++) begin
			for (int k = 0; k < MAX_PROCS; k++) begin
				lvl_mask[l][k] = (CNT_W'(k) < count_q) && (level_q[k] == 3'(l + 1)) &&
					((3'(l + 1) > serv_q) ||
					 ((3'(l + 1) == serv_q) && (CNT_W'(k) >= scan_q)));
			end
		end
		found    = 1'b1;
		plvl     = LVL_NONE;
		sel_mask = '0;
		if (|lvl_mask[0]) begin
			plvl     = LVL_FIRST;
			sel_mask = lvl_mask[0];
		end else if (|lvl_mask[1]) begin
			plvl     = LVL_SECOND;
			sel_mask = lvl_mask[1];
		end else if (|lvl_mask[2]) begin
			plvl     = LVL_THIRD;
			sel_mask = lvl_mask[2];
		end else if (|lvl_mask[3]) begin
			plvl     = LVL_LAST;
			sel_mask = lvl_mask[3];
		end else begin
			found = 1'b0;
		end
		pick = '0;
		for (int k = MAX_PROCS - 1; k >= 0; k--) begin
			if (sel_mask[k]) pick = IDX_W'(k);
		end
	end

	assign rem_cur    = rem_q[pick];
	assign after      = rem_cur - 8'd1;
	// a different process or level starts a fresh slice
	assign slice_base = ((CNT_W'(pick) != scan_q) || (plvl != serv_q)) ? 6'd0 : slice_q;
	assign slice_inc  = slice_base + 6'd1;

	always_comb begin
		case (plvl)
			LVL_FIRST:  qsel = quant1_q;
			LVL_SECOND: qsel = quant2_q;
			default:    qsel = quant3_q;
		endcase
		qeff = (qsel == 6'd0) ? 6'd1 : qsel;
	end

	always_comb begin
		for (int k = 0; k < MAX_PROCS; k++) level_d[k] = level_q[k];
		count_d   = count_q;
		serv_d    = serv_q;
		scan_d    = scan_q;
		slice_d   = slice_q;
		running_d = running_q;
		rem_we    = 1'b0;
		rem_idx   = pick;
		rem_wdata = after;
		res_d     = '0;
		case (item_q.action)
			ACT_LOAD: begin
				if (running_q || (count_q >= CNT_W'(MAX_PROCS)) ||
				    (item_q.burst_time > max_burst_q)) begin
					res_d.load_rejected = 1'b1;
				end else begin
					rem_we    = 1'b1;
					rem_idx   = count_q[IDX_W-1:0];
					rem_wdata = item_q.burst_time;
					level_d[count_q[IDX_W-1:0]] =
						(item_q.burst_time != 8'd0) ? LVL_FIRST : LVL_NONE;
					count_d   = count_q + CNT_W'(1);
					res_d.load_accepted = 1'b1;
				end
			end
			ACT_TICK: begin
				running_d = 1'b1;
				if (found) begin
					rem_we          = 1'b1;
					res_d.ran       = 1'b1;
					res_d.process_id = 4'(pick);
					res_d.run_level = plvl;
					res_d.time_left = rem_cur;
					serv_d          = plvl;
					scan_d          = CNT_W'(pick);
					slice_d         = slice_inc;
					if (after == 8'd0) begin
						level_d[pick]  = LVL_NONE;
						res_d.finished = 1'b1;
						scan_d         = CNT_W'(pick) + CNT_W'(1);
						slice_d        = 6'd0;
					end else if ((plvl < LVL_LAST) && (slice_inc >= qeff)) begin
						level_d[pick] = plvl + 3'd1;
						res_d.demoted = 1'b1;
						scan_d        = CNT_W'(pick) + CNT_W'(1);
						slice_d       = 6'd0;
					end
				end else begin
					serv_d  = LVL_LAST;
					scan_d  = count_q;
					slice_d = 6'd0;
				end
			end
			ACT_RESTART: begin
				for (int k = 0; k < MAX_PROCS; k++) level_d[k] = LVL_NONE;
				count_d   = '0;
				serv_d    = LVL_FIRST;
				scan_d    = '0;
				slice_d   = 6'd0;
				running_d = 1'b0;
			end
			default: begin
			end
		endcase
		any_left = 1'b0;
		for (int k = 0; k < MAX_PROCS; k++) begin
			if (level_d[k] != LVL_NONE) any_left = 1'b1;
		end
		res_d.all_done = !any_left;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant1_q    <= 6'd5;
			quant2_q    <= 6'd10;
			quant3_q    <= 6'd15;
			max_burst_q <= 8'd200;
			for (int k = 0; k < MAX_PROCS; k++) level_q[k] <= LVL_NONE;
			count_q   <= '0;
			serv_q    <= LVL_FIRST;
			scan_q    <= '0;
			slice_q   <= 6'd0;
			running_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_QUANTUM_FIRST:  quant1_q    <= cfg_data[5:0];
					CFG_QUANTUM_SECOND: quant2_q    <= cfg_data[5:0];
					CFG_QUANTUM_THIRD:  quant3_q    <= cfg_data[5:0];
					CFG_MAX_BURST:      max_burst_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.exec) begin
				for (int k = 0; k < MAX_PROCS; k++) level_q[k] <= level_d[k];
				count_q   <= count_d;
				serv_q    <= serv_d;
				scan_q    <= scan_d;
				slice_q   <= slice_d;
				running_q <= running_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= req;
		if (cmd.exec) begin
			res_q <= res_d;
			if (rem_we) rem_q[rem_idx] <= rem_wdata;
		end
	end

	assign res = res_q;

endmodule

// ===== hw/rtl/multilevel_feedback_tick_scheduler.sv =====
// Four-level feedback scheduler over a table of sixteen processes. Load requests
// append a process with its burst time (refused past max_burst, into a full table,
// or once ticking has begun); tick requests run one time unit of the next process,
// serving levels one to three in index order with per-level quanta and demotion,
// and level four to completion; restart clears the table but keeps the
// configuration. Each request yields exactly one result. A request is first
// registered; then the find-first over all table entries and the table update
// complete and the result sits in an output register. The next request is taken
// only after the previous one has completed and that register is empty or being
// read, so one request is in flight at a time. Configuration writes take effect
// at once and belong in idle periods.
module multilevel_feedback_tick_scheduler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  mfts_pkg::req_item_t req,
	output logic                res_valid,
	input  logic                res_stall,
	output mfts_pkg::res_item_t res,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	import mfts_pkg::*;

	dp_cmd_t cmd;

	mfts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd)
	);

	mfts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res)
	);

endmodule

// ===== hw/rtl/mfts_checker.sv =====
module mfts_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                res_valid,
	input logic                res_stall,
	input mfts_pkg::res_item_t res
);
	import mfts_pkg::*;

	// a pending result is not dropped
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	// one request in flight at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one in flight");

	// every taken request yields its result once it has been registered and executed
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> ##1 res_valid)
		else $error("result missing after request");

	// a result reports at most one kind of outcome
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.load_accepted && res.load_rejected) &&
			!(res.ran && (res.load_accepted || res.load_rejected)) &&
			!(res.demoted && res.finished))
		else $error("conflicting result flags");

	// a finishing tick ran its last unit
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.finished |-> res.ran && (res.time_left == 8'd1) &&
			(res.run_level != LVL_NONE))
		else $error("finish without a last unit");

endmodule

bind multilevel_feedback_tick_scheduler mfts_checker u_mfts_checker (.*);
